// ===== rtl/core/kstc_pkg.sv =====
// ----------------------------------------------------------------------------
// kstc_pkg
// Shared widths, defaults and sequencer states of the spanning-tree cost block.
// ----------------------------------------------------------------------------
package kstc_pkg;

   localparam int MAX_NODE_DEF   = 1023;
   localparam int TOTAL_BITS_DEF = 32;

   localparam int NODE_ID_W  = 10;
   localparam int JOINS_W    = 10;
   localparam int COST_W     = 24;
   localparam int OUT_TOT_W  = 32;

   localparam logic [JOINS_W-1:0] JOINS_RESET = 10'd1023;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_CHECK,
      ST_FIND_RD,
      ST_FIND_CHK,
      ST_COMP_RD,
      ST_COMP_CHK,
      ST_UNION_LO,
      ST_UNION_HI,
      ST_FINISH
   } seq_state_type;

endpackage

// ===== rtl/core/kruskal_spanning_tree_cost.sv =====
// ----------------------------------------------------------------------------
// kruskal_spanning_tree_cost
// Union-find forest (union by size, path compression) that sums the cost of
// edges joining two sets, one request at a time.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_ready  start_graph, node_a, node_b, edge_cost
//  rsp      out        rsp_valid/rsp_ready  accepted, total_cost, tree_complete,
//                                           cost_saturated
//  csr      in         csr_valid/csr_ready  required_joins
//
//  A merging request steps through CHECK, then for each end a find walk up the
//  parent links to the root and a compression pass that rewrites the entries
//  walked, then UNION_LO, UNION_HI and FINISH; an edge whose ends share a root
//  skips the two union steps, and an ignored edge goes from CHECK to FINISH.
//  The single forest RAM read port sets this, one step a cycle unless rsp stalls.
//  A start_graph request first sweeps every entry of the forest RAM.
//  After reset the same sweep runs before req_ready rises.
//  A finished result holds in the rsp register; a stalled rsp holds the next
//  request in its last step until the register frees up.
// ----------------------------------------------------------------------------
module kruskal_spanning_tree_cost #(
   parameter int MAX_NODE   = kstc_pkg::MAX_NODE_DEF,
   parameter int TOTAL_BITS = kstc_pkg::TOTAL_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_start_graph,
   input  logic [kstc_pkg::NODE_ID_W-1:0]     req_node_a,
   input  logic [kstc_pkg::NODE_ID_W-1:0]     req_node_b,
   input  logic [kstc_pkg::COST_W-1:0]        req_edge_cost,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_accepted,
   output logic [kstc_pkg::OUT_TOT_W-1:0]     rsp_total_cost,
   output logic                               rsp_tree_complete,
   output logic                               rsp_cost_saturated,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [kstc_pkg::JOINS_W-1:0]       csr_required_joins
);
   import kstc_pkg::*;

   localparam int NODE_COUNT = MAX_NODE + 1;
   localparam int NB         = $clog2(NODE_COUNT);
   localparam int SB         = NB + 1;
   localparam int WORD_W     = NB + SB;
   localparam int SUM_W      = ((TOTAL_BITS > COST_W) ? TOTAL_BITS : COST_W) + 1;
   localparam logic [SUM_W-1:0] TOTAL_MAX = SUM_W'((65'd1 << TOTAL_BITS) - 65'd1);
   localparam logic [16:0] NODE_LIMIT = 17'(MAX_NODE);

   seq_state_type state_ff, state_in;

   logic [JOINS_W-1:0]    req_joins_ff;
   logic [JOINS_W-1:0]    joins_ff;
   logic [TOTAL_BITS-1:0] total_ff;
   logic                  sat_ff;
   logic                  pend_ff;

   logic [NODE_ID_W-1:0]  a_ff, b_ff;
   logic [COST_W-1:0]     cost_ff;

   logic [NB-1:0]         clr_cnt_ff;
   logic [NB-1:0]         cur_ff;
   logic [NB-1:0]         root_ff;
   logic [NB-1:0]         ra_ff;
   logic [SB-1:0]         size_a_ff, size_b_ff;
   logic                  side_ff;
   logic                  acc_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_acc_ff, rsp_done_ff, rsp_sat_ff;
   logic [OUT_TOT_W-1:0]  rsp_total_ff;

   logic                  wr_en;
   logic [NB-1:0]         wr_addr, rd_addr;
   logic [WORD_W-1:0]     wr_data, rd_data;
   logic [NB-1:0]         rd_parent;
   logic [SB-1:0]         rd_size;

   logic                  in_range;
   logic                  rsp_free;
   logic                  last_clear;
   logic                  a_smaller;
   logic [NB-1:0]         hi_root, lo_root;
   logic [SUM_W-1:0]      sum;
   logic [TOTAL_BITS-1:0] total_next;

   kstc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NODE_COUNT)
   ) u_forest (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_parent  = rd_data[WORD_W-1:SB];
   assign rd_size    = rd_data[SB-1:0];
   assign in_range   = (17'(a_ff) <= NODE_LIMIT) && (17'(b_ff) <= NODE_LIMIT);
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign last_clear = (clr_cnt_ff == NB'(MAX_NODE));
   assign a_smaller  = (size_a_ff < size_b_ff);
   assign hi_root    = a_smaller ? root_ff : ra_ff;
   assign lo_root    = a_smaller ? ra_ff : root_ff;
   assign sum        = SUM_W'(total_ff) + SUM_W'(cost_ff);
   assign total_next = (sum > TOTAL_MAX) ? TOTAL_BITS'(TOTAL_MAX) : TOTAL_BITS'(sum);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = req_start_graph ? ST_CLEAR : ST_CHECK;
            end
         end
         ST_CLEAR: begin
            if (last_clear) begin
               state_in = pend_ff ? ST_CHECK : ST_IDLE;
            end
         end
         ST_CHECK: begin
            state_in = (joins_ff != '0 && in_range) ? ST_FIND_RD : ST_FINISH;
         end
         ST_FIND_RD:  state_in = ST_FIND_CHK;
         ST_FIND_CHK: begin
            if (rd_parent == cur_ff) begin
               state_in = ST_COMP_RD;
            end
         end
         ST_COMP_RD:  state_in = ST_COMP_CHK;
         ST_COMP_CHK: begin
            if (rd_parent == root_ff) begin
               if (!side_ff) begin
                  state_in = ST_FIND_RD;
               end else begin
                  state_in = (root_ff == ra_ff) ? ST_FINISH : ST_UNION_LO;
               end
            end
         end
         ST_UNION_LO: state_in = ST_UNION_HI;
         ST_UNION_HI: state_in = ST_FINISH;
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // RAM port and handshake outputs
   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = cur_ff;
      wr_data   = {root_ff, rd_size};
      rd_addr   = cur_ff;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_ff;
            wr_data = {clr_cnt_ff, SB'(1)};
         end
         ST_FIND_CHK: rd_addr = rd_parent;
         ST_COMP_CHK: begin
            rd_addr = rd_parent;
            if (rd_parent != root_ff) begin
               wr_en = 1'b1;
            end
         end
         ST_UNION_LO: begin
            wr_en   = 1'b1;
            wr_addr = lo_root;
            wr_data = {hi_root, a_smaller ? size_a_ff : size_b_ff};
         end
         ST_UNION_HI: begin
            wr_en   = 1'b1;
            wr_addr = hi_root;
            wr_data = {hi_root, SB'(size_a_ff + size_b_ff)};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         req_joins_ff <= JOINS_RESET;
         joins_ff     <= JOINS_RESET;
         total_ff     <= '0;
         sat_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            req_joins_ff <= csr_required_joins;
         end
         if (state_ff == ST_FINISH && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  pend_ff    <= 1'b1;
                  clr_cnt_ff <= '0;
                  if (req_start_graph) begin
                     joins_ff <= req_joins_ff;
                     total_ff <= '0;
                     sat_ff   <= 1'b0;
                  end
               end
            end
            ST_CLEAR: clr_cnt_ff <= clr_cnt_ff + NB'(1);
            ST_UNION_HI: begin
               joins_ff <= joins_ff - JOINS_W'(1);
               total_ff <= total_next;
               if (SUM_W'(total_next) == TOTAL_MAX) begin
                  sat_ff <= 1'b1;
               end
            end
            ST_FINISH: begin
               if (rsp_free) begin
                  pend_ff <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            a_ff     <= req_node_a;
            b_ff     <= req_node_b;
            cost_ff  <= req_edge_cost;
         end
         ST_CHECK: begin
            acc_ff  <= 1'b0;
            side_ff <= 1'b0;
            cur_ff  <= NB'(a_ff);
         end
         ST_FIND_CHK: begin
            if (rd_parent == cur_ff) begin
               root_ff <= cur_ff;
               cur_ff  <= side_ff ? NB'(b_ff) : NB'(a_ff);
               if (side_ff) begin
                  size_b_ff <= rd_size;
               end else begin
                  size_a_ff <= rd_size;
               end
            end else begin
               cur_ff <= rd_parent;
            end
         end
         ST_COMP_CHK: begin
            if (rd_parent == root_ff) begin
               if (!side_ff) begin
                  ra_ff   <= root_ff;
                  side_ff <= 1'b1;
                  cur_ff  <= NB'(b_ff);
               end
            end else begin
               cur_ff <= rd_parent;
            end
         end
         ST_UNION_HI: acc_ff <= 1'b1;
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_acc_ff   <= acc_ff;
               rsp_total_ff <= OUT_TOT_W'(total_ff);
               rsp_done_ff  <= (joins_ff == '0);
               rsp_sat_ff   <= sat_ff;
            end
         end
         default: ;
      endcase
   end

   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accepted       = rsp_acc_ff;
   assign rsp_total_cost     = rsp_total_ff;
   assign rsp_tree_complete  = rsp_done_ff;
   assign rsp_cost_saturated = rsp_sat_ff;

   // a compressing write never lands on the entry being read in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      (wr_en && state_ff == ST_COMP_CHK) |-> (wr_addr != rd_addr))
      else $error("forest write collides with read");

   // each merge uses up exactly one join
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UNION_HI) |=> (joins_ff == $past(joins_ff) - JOINS_W'(1)))
      else $error("join count not decremented on merge");

   // the saturation flag implies the total sits at its maximum
   assert property (@(posedge clock) disable iff (reset)
      sat_ff |-> (SUM_W'(total_ff) == TOTAL_MAX))
      else $error("saturation flag set below maximum total");

   // a merge only follows two distinct roots
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UNION_LO) |-> (ra_ff != root_ff))
      else $error("merge of a set with itself");

endmodule

// ===== rtl/core/kstc_ram.sv =====
// ----------------------------------------------------------------------------
// kstc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module kstc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sim/tb_kruskal_spanning_tree_cost.sv =====
// ----------------------------------------------------------------------------
// tb_kruskal_spanning_tree_cost
// Drives edge requests and joins settings into the spanning-tree cost block.
// A scoreboard keeps its own union-find forest, predicts every response and
// checks it field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_kruskal_spanning_tree_cost;
   timeunit 1ns;
   timeprecision 1ps;

   import kstc_pkg::*;

   localparam int NODES = MAX_NODE_DEF + 1;
   localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

   typedef struct {
      logic                 accepted;
      logic [OUT_TOT_W-1:0] total_cost;
      logic                 tree_complete;
      logic                 cost_saturated;
   } tree_result_type;

   class tree_scoreboard_type;
      int unsigned          parent[NODES];
      int unsigned          set_size[NODES];
      logic [JOINS_W-1:0]   joins_setting;
      logic [JOINS_W-1:0]   joins_left;
      logic [OUT_TOT_W-1:0] total;
      logic                 saturated;
      tree_result_type      expected_q[$];
      int                   errors;

      function new();
         joins_setting = JOINS_RESET;
         errors = 0;
         clear_forest();
      endfunction

      function void clear_forest();
         for (int i = 0; i < NODES; i++) begin
            parent[i] = i;
            set_size[i] = 1;
         end
         joins_left = joins_setting;
         total = '0;
         saturated = 1'b0;
      endfunction

      function int unsigned find_root(int unsigned x);
         int unsigned r;
         int unsigned nxt;
         r = x;
         while (parent[r] != r) r = parent[r];
         // compress the walked chain onto the root
         while (parent[x] != r) begin
            nxt = parent[x];
            parent[x] = r;
            x = nxt;
         end
         return r;
      endfunction

      function void note_request(logic start, logic [NODE_ID_W-1:0] a,
                                 logic [NODE_ID_W-1:0] b, logic [COST_W-1:0] cost);
         tree_result_type res;
         int unsigned  ra;
         int unsigned  rb;
         int unsigned  t;
         logic [OUT_TOT_W:0] sum;
         if (start) clear_forest();
         res.accepted = 1'b0;
         if (joins_left != 0) begin
            ra = find_root(a);
            rb = find_root(b);
            if (ra != rb) begin
               if (set_size[ra] < set_size[rb]) begin
                  t = ra; ra = rb; rb = t;
               end
               parent[rb] = ra;
               set_size[ra] += set_size[rb];
               joins_left--;
               sum = {1'b0, total} + cost;
               total = sum[OUT_TOT_W] ? {OUT_TOT_W{1'b1}} : sum[OUT_TOT_W-1:0];
               if (total == {OUT_TOT_W{1'b1}}) saturated = 1'b1;
               res.accepted = 1'b1;
            end
         end
         res.total_cost = total;
         res.tree_complete = (joins_left == 0);
         res.cost_saturated = saturated;
         expected_q.insert(expected_q.size(), res);
      endfunction

      task report(string what, longint got, longint want);
         $display("mismatch %s: got %0h expected %0h", what, got, want);
         errors++;
      endtask

      task check_result(tree_result_type got);
         tree_result_type want;
         if (expected_q.size() == 0) begin
            report("response with no request pending", 0, 0);
         end else begin
            want = expected_q.pop_front();
            if (got.accepted !== want.accepted)
               report("accepted", got.accepted, want.accepted);
            if (got.total_cost !== want.total_cost)
               report("total_cost", got.total_cost, want.total_cost);
            if (got.tree_complete !== want.tree_complete)
               report("tree_complete", got.tree_complete, want.tree_complete);
            if (got.cost_saturated !== want.cost_saturated)
               report("cost_saturated", got.cost_saturated, want.cost_saturated);
         end
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_start_graph = 1'b0;
   logic [NODE_ID_W-1:0] req_node_a = '0;
   logic [NODE_ID_W-1:0] req_node_b = '0;
   logic [COST_W-1:0]    req_edge_cost = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_accepted;
   logic [OUT_TOT_W-1:0] rsp_total_cost;
   logic                 rsp_tree_complete;
   logic                 rsp_cost_saturated;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [JOINS_W-1:0]   csr_required_joins = '0;

   tree_scoreboard_type sb = new();
   int             idle_cycles = 0;
   logic [COST_W-1:0] cost_now;

   kruskal_spanning_tree_cost u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_start_graph(req_start_graph), .req_node_a(req_node_a),
      .req_node_b(req_node_b), .req_edge_cost(req_edge_cost),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_accepted(rsp_accepted), .rsp_total_cost(rsp_total_cost),
      .rsp_tree_complete(rsp_tree_complete), .rsp_cost_saturated(rsp_cost_saturated),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_required_joins(csr_required_joins)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog: no handshake on any channel for too long ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 20000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // response side: random stall before each response
   initial begin
      tree_result_type got;
      int           gap;
      @(negedge clock);
      forever begin
         gap = $urandom_range(0, 16);
         if (gap > 0) begin
            rsp_ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got.accepted = rsp_accepted;
         got.total_cost = rsp_total_cost;
         got.tree_complete = rsp_tree_complete;
         got.cost_saturated = rsp_cost_saturated;
         sb.check_result(got);
         @(negedge clock);
      end
   end

   // called at a falling edge, returns at a falling edge
   task send_edge(logic start, logic [NODE_ID_W-1:0] a, logic [NODE_ID_W-1:0] b,
                  logic [COST_W-1:0] cost);
      int gap;
      gap = $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_start_graph = start;
      req_node_a = a;
      req_node_b = b;
      req_edge_cost = cost;
      do @(posedge clock); while (!req_ready);
      sb.note_request(start, a, b, cost);
      @(negedge clock);
   endtask

   task drain();
      req_valid = 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task write_joins(logic [JOINS_W-1:0] joins);
      csr_valid = 1'b1;
      csr_required_joins = joins;
      do @(posedge clock); while (!csr_ready);
      sb.joins_setting = joins;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // one graph: edges in a node window with rising cost, plus some noise
   task random_graph(int n_edges);
      int unsigned span;
      int unsigned base;
      logic [NODE_ID_W-1:0] a;
      logic [NODE_ID_W-1:0] b;
      logic [COST_W-1:0] cost;
      int unsigned step;
      span = ($urandom_range(0, 7) == 0) ? NODES : $urandom_range(2, 64);
      base = $urandom_range(0, NODES - span);
      step = 1 << $urandom_range(0, 20);
      for (int i = 0; i < n_edges; i++) begin
         a = NODE_ID_W'(base + $urandom_range(0, span - 1));
         b = NODE_ID_W'(base + $urandom_range(0, span - 1));
         if ($urandom_range(0, 9) == 0) begin
            a = NODE_ID_W'($urandom);
            b = NODE_ID_W'($urandom);
         end
         if ($urandom_range(0, 29) == 0)
            cost = COST_W'($urandom);
         else if (cost_now > COST_MAX - step)
            cost = COST_MAX;
         else
            cost = COST_W'(cost_now + $urandom_range(0, step));
         cost_now = cost;
         send_edge(i == 0 || $urandom_range(0, 49) == 0, a, b, cost);
      end
   endtask

   initial begin
      int joins_list[7];
      joins_list = '{1, 5, 37, 200, 1023, 0, 682};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: joins of three, self loop, extreme ids and cost, completion
      write_joins(10'd3);
      send_edge(1'b1, 10'd0, 10'd1, 24'd0);
      send_edge(1'b0, 10'd2, 10'd2, 24'd5);
      send_edge(1'b0, 10'd1, 10'd0, 24'd6);
      send_edge(1'b0, 10'd1023, 10'd512, COST_MAX);
      send_edge(1'b0, 10'd512, 10'd0, COST_MAX);
      send_edge(1'b0, 10'd3, 10'd4, COST_MAX);
      send_edge(1'b0, 10'd341, 10'd682, 24'd7);
      drain();
      // new setting waits for the next start
      write_joins(10'd1);
      send_edge(1'b0, 10'd5, 10'd6, 24'h555555);
      send_edge(1'b1, 10'd5, 10'd6, 24'haaaaaa);
      send_edge(1'b0, 10'd7, 10'd8, 24'haaaaaa);
      drain();
      // saturate the total with a long chain of max-cost edges
      write_joins(10'd1023);
      for (int i = 0; i < 300; i++)
         send_edge(i == 0, i[NODE_ID_W-1:0], NODE_ID_W'(i + 1), COST_MAX);
      drain();

      foreach (joins_list[k]) begin
         write_joins(JOINS_W'(joins_list[k]));
         cost_now = COST_W'($urandom);
         send_edge(1'b0, NODE_ID_W'($urandom), NODE_ID_W'($urandom), cost_now);
         for (int g = 0; g < 3; g++) begin
            cost_now = ($urandom_range(0, 3) == 0) ? COST_MAX - 24'd4000
                                                   : COST_W'($urandom_range(0, 4000));
            random_graph($urandom_range(40, 90));
         end
         drain();
      end

      if (sb.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
